// ----- rtl/core/dpt_pkg.sv -----
// ----------------------------------------------------------------------------
// dpt_pkg
// shared types and constants for the primality tester
// ----------------------------------------------------------------------------
`default_nettype none
package dpt_pkg;
    localparam int NumW = 64;
    localparam int WitCnt = 12;
    localparam int WitIdxW = 4;

    typedef logic [NumW-1:0] num_t;

    // modular multiplier control toward the serial unit
    typedef struct packed {
        logic start;
        num_t a;
        num_t b;
        num_t m;
    } mul_req_t;

    typedef struct packed {
        logic done;
        num_t p;
    } mul_rsp_t;

    function automatic logic [5:0] witness(input logic [WitIdxW-1:0] k);
        logic [5:0] w;
        case (k)
            4'd0: w = 6'd2;
            4'd1: w = 6'd3;
            4'd2: w = 6'd5;
            4'd3: w = 6'd7;
            4'd4: w = 6'd11;
            4'd5: w = 6'd13;
            4'd6: w = 6'd17;
            4'd7: w = 6'd19;
            4'd8: w = 6'd23;
            4'd9: w = 6'd29;
            4'd10: w = 6'd31;
            4'd11: w = 6'd37;
            default: w = 6'd2;
        endcase
        return w;
    endfunction
endpackage
`default_nettype wire

// ----- rtl/core/dpt_modmul.sv -----
// ----------------------------------------------------------------------------
// dpt_modmul
// bit-serial modular multiplier, msb first double-and-add; takes a new request only when idle
// ----------------------------------------------------------------------------
`default_nettype none
module dpt_modmul (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dpt_pkg::mul_req_t req,
    output dpt_pkg::mul_rsp_t      rsp
);
    import dpt_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DBL, S_ADD} state_t;

    state_t state_reg, state_next;
    num_t acc_reg, acc_next;
    num_t x_reg, x_next;
    num_t y_reg, y_next;
    num_t m_reg, m_next;
    logic [6:0] cnt_reg, cnt_next;
    logic done_reg, done_next;

    // mod add of acc with an operand: gap to m, compare, then add or subtract
    num_t addend, gap, sum;
    always_comb
    begin
        addend = (state_reg == S_DBL) ? acc_reg : x_reg;
        gap = m_reg - addend;
        sum = (acc_reg >= gap) ? (acc_reg - gap) : (acc_reg + addend);
    end

    always_comb
    begin
        state_next = state_reg;
        acc_next = acc_reg;
        x_next = x_reg;
        y_next = y_reg;
        m_next = m_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    acc_next = '0;
                    x_next = req.a;
                    y_next = req.b;
                    m_next = req.m;
                    cnt_next = 7'(NumW);
                    state_next = S_DBL;
                end
            end
            S_DBL:
            begin
                acc_next = sum;
                cnt_next = cnt_reg - 7'd1;
                if (y_reg[NumW-1])
                    state_next = S_ADD;
                else
                begin
                    y_next = y_reg << 1;
                    if (cnt_reg == 7'd1)
                    begin
                        state_next = S_IDLE;
                        done_next = 1'b1;
                    end
                end
            end
            S_ADD:
            begin
                acc_next = sum;
                y_next = y_reg << 1;
                if (cnt_reg == 7'd0)
                begin
                    state_next = S_IDLE;
                    done_next = 1'b1;
                end
                else
                    state_next = S_DBL;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg <= x_next;
        y_reg <= y_next;
        m_reg <= m_next;
    end

    assign rsp.done = done_reg;
    assign rsp.p = acc_reg;
endmodule
`default_nettype wire

// ----- rtl/core/dpt_divchk.sv -----
// ----------------------------------------------------------------------------
// dpt_divchk
// serial remainder of n by a small witness, one bit per cycle msb first
// ----------------------------------------------------------------------------
`default_nettype none
module dpt_divchk (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire dpt_pkg::num_t          n,
    input  wire logic [5:0]             divisor,
    output logic                        done,
    output logic                        zero_rem
);
    import dpt_pkg::*;

    num_t sh_reg, sh_next;
    logic [5:0] rem_reg, rem_next;
    logic [6:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [6:0] trial;

    always_comb
    begin
        trial = {rem_reg, sh_reg[NumW-1]};
        sh_next = sh_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            sh_next = n;
            rem_next = '0;
            cnt_next = 7'(NumW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = (trial >= {1'b0, divisor}) ? 6'(trial - {1'b0, divisor})
                                                  : trial[5:0];
            sh_next = sh_reg << 1;
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign zero_rem = (rem_reg == '0);
endmodule
`default_nettype wire

// ----- rtl/core/deterministic_primality_tester.sv -----
// ----------------------------------------------------------------------------
// deterministic_primality_tester
// deterministic miller-rabin test of a 64-bit number, witnesses 2..37
// ----------------------------------------------------------------------------
// channel   dir  tdata                   tuser  tlast
// s_axis    in   [63:0] number           -      -
// m_axis    out  [0] prime_flag (7 pad)  -      -
//
// one item at a time; the modular products run one after another in the
// serial multiplier and set the rate: up to ~1500 products for a strong
// prime; the twelve trial divisions run serially before the first witness
// reset clears all control; the result register holds until taken and the
// input stays closed until then
`default_nettype none
module deterministic_primality_tester (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // [63:0] number
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata    // [0] prime_flag, [7:1] zero
);
    import dpt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_DIVW, S_WIT, S_POWSTEP, S_POWW, S_SQB, S_SQBW,
        S_CHK, S_SQX, S_SQXW, S_OUT
    } state_t;

    state_t state_reg;
    num_t n_reg, d_reg, e_reg, b_reg, x_reg, top_reg;
    logic [5:0] r_reg, i_reg;
    logic [WitIdxW-1:0] k_reg;
    logic res_reg, ovalid_reg;

    mul_req_t mreq;
    mul_rsp_t mrsp;
    logic dv_start, dv_done, dv_zero;
    logic [5:0] wit;
    logic wit_pass;

    assign wit = witness(k_reg);

    dpt_modmul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

    dpt_divchk u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start), .n(n_reg),
        .divisor(wit), .done(dv_done), .zero_rem(dv_zero)
    );

    assign s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = {7'd0, res_reg};
    assign dv_start = (state_reg == S_DIV);

    // the current witness is satisfied
    assign wit_pass = (state_reg == S_CHK && (x_reg == 64'd1 || x_reg == top_reg)) ||
                      (state_reg == S_SQXW && mrsp.done && mrsp.p == top_reg);

    // multiplier operands by state
    always_comb
    begin
        mreq.start = 1'b0;
        mreq.a = x_reg;
        mreq.b = b_reg;
        mreq.m = n_reg;
        case (state_reg)
            S_POWSTEP: mreq.start = e_reg[0];
            S_SQB:
            begin
                mreq.start = 1'b1;
                mreq.a = b_reg;
            end
            S_SQX:
            begin
                mreq.start = 1'b1;
                mreq.b = x_reg;
            end
            default: mreq.start = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ovalid_reg <= 1'b0;
            res_reg <= 1'b0;
            k_reg <= '0;
            r_reg <= '0;
            i_reg <= '0;
            n_reg <= '0;
            d_reg <= '0;
            e_reg <= '0;
            b_reg <= '0;
            x_reg <= '0;
            top_reg <= '0;
        end
        else
        begin
            if (ovalid_reg && m_axis_tready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        n_reg <= s_axis_tdata;
                        top_reg <= s_axis_tdata - 64'd1;
                        k_reg <= '0;
                        if (s_axis_tdata < 64'd4 || !s_axis_tdata[0])
                        begin
                            res_reg <= (s_axis_tdata == 64'd2) || (s_axis_tdata == 64'd3);
                            state_reg <= S_OUT;
                        end
                        else
                            state_reg <= S_DIV;
                    end
                end
                S_DIV: state_reg <= S_DIVW;
                S_DIVW:
                begin
                    if (dv_done)
                    begin
                        if (n_reg == 64'(wit))
                        begin
                            res_reg <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else if (dv_zero)
                        begin
                            res_reg <= 1'b0;
                            state_reg <= S_OUT;
                        end
                        else if (k_reg == 4'(WitCnt - 1))
                        begin
                            // n > 37 and odd: split n-1 one bit per cycle below
                            k_reg <= '0;
                            d_reg <= top_reg;
                            r_reg <= '0;
                            state_reg <= S_WIT;
                        end
                        else
                        begin
                            k_reg <= k_reg + 4'd1;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_WIT:
                begin
                    if (!d_reg[0])
                    begin
                        d_reg <= d_reg >> 1;
                        r_reg <= r_reg + 6'd1;
                    end
                    else
                    begin
                        e_reg <= d_reg;
                        b_reg <= 64'(wit);
                        x_reg <= 64'd1;
                        state_reg <= S_POWSTEP;
                    end
                end
                S_POWSTEP:
                begin
                    if (e_reg == '0)
                        state_reg <= S_CHK;
                    else if (e_reg[0])
                        state_reg <= S_POWW;
                    else
                        state_reg <= S_SQB;
                end
                S_POWW:
                begin
                    if (mrsp.done)
                    begin
                        x_reg <= mrsp.p;
                        state_reg <= S_SQB;
                    end
                end
                S_SQB:
                begin
                    e_reg <= e_reg >> 1;
                    state_reg <= S_SQBW;
                end
                S_SQBW:
                begin
                    if (mrsp.done)
                    begin
                        b_reg <= mrsp.p;
                        state_reg <= S_POWSTEP;
                    end
                end
                S_CHK:
                begin
                    i_reg <= 6'd1;
                    if (!wit_pass)
                    begin
                        if (r_reg > 6'd1)
                            state_reg <= S_SQX;
                        else
                        begin
                            res_reg <= 1'b0;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_SQX: state_reg <= S_SQXW;
                S_SQXW:
                begin
                    if (mrsp.done)
                    begin
                        x_reg <= mrsp.p;
                        if (!wit_pass)
                        begin
                            if (i_reg + 6'd1 < r_reg)
                            begin
                                i_reg <= i_reg + 6'd1;
                                state_reg <= S_SQX;
                            end
                            else
                            begin
                                res_reg <= 1'b0;
                                state_reg <= S_OUT;
                            end
                        end
                    end
                end
                S_OUT:
                begin
                    if (!ovalid_reg)
                    begin
                        ovalid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            // a witness passes: move to the next one or finish prime
            if (wit_pass)
            begin
                if (k_reg == 4'(WitCnt - 1))
                begin
                    res_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                else
                begin
                    k_reg <= k_reg + 4'd1;
                    d_reg <= top_reg;
                    r_reg <= '0;
                    state_reg <= S_WIT;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/dpt_checker.sv -----
// ----------------------------------------------------------------------------
// dpt_checker
// port-level checks on the primality tester
// ----------------------------------------------------------------------------
`default_nettype none
module dpt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata
);
    // result waits hold
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");
    // pad bits stay zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
        else $error("pad bits set");
    // no new item while a result waits
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input open while result pending");
    // an accepted item gives no result in the next cycle
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result too early");
endmodule

bind deterministic_primality_tester dpt_checker u_dpt_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
